/* src/bfse_pkg.sv */
package bfse_pkg;

    localparam int TAPE_DEPTH_DEF = 32768;
    localparam int PROG_DEPTH_DEF = 4096;
    localparam int NPC_W          = 13;
    localparam int ERR_W          = 3;

    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_INC   = 8'h2B;
    localparam logic [7:0] CH_DEC   = 8'h2D;
    localparam logic [7:0] CH_OUT   = 8'h2E;
    localparam logic [7:0] CH_IN    = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
    localparam logic [ERR_W-1:0] ERR_OVF   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_UNF   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_OPEN  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_CLOSE = 3'd4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_RIGHT,
        OP_LEFT,
        OP_INC,
        OP_DEC,
        OP_OUT,
        OP_IN,
        OP_OPEN,
        OP_CLOSE
    } op_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic step_start;
        logic exec_plain;
        logic exec_halted;
        logic scan_start;
        logic scan_step;
        logic scan_found;
        logic scan_fail;
        logic fwd;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic halted;
        logic out_free;
        op_t  op;
        logic cell_zero;
        logic fwd_more;
        logic bwd_more;
        logic hit;
    } status_t;

    function automatic op_t decode_op(input logic [7:0] ch);
        op_t op;
        unique case (ch)
            CH_RIGHT: op = OP_RIGHT;
            CH_LEFT:  op = OP_LEFT;
            CH_INC:   op = OP_INC;
            CH_DEC:   op = OP_DEC;
            CH_OUT:   op = OP_OUT;
            CH_IN:    op = OP_IN;
            CH_OPEN:  op = OP_OPEN;
            CH_CLOSE: op = OP_CLOSE;
            default:  op = OP_NOP;
        endcase
        return op;
    endfunction

endpackage

/* src/bfse_ctrl.sv */
module bfse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tuser,
    output logic              s_tready,
    input  bfse_pkg::status_t status,
    output bfse_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_SCANF = 5'b01000,
        ST_SCANB = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg) inside
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        cmd.step_start = 1'b1;
                        state_next     = ST_EXEC;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_EXEC:
            begin
                if (status.halted)
                begin
                    if (status.out_free)
                    begin
                        cmd.exec_halted = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (status.op == bfse_pkg::OP_OPEN && status.cell_zero)
                begin
                    cmd.fwd = 1'b1;
                    if (status.fwd_more)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCANF;
                    end
                    else if (status.out_free)
                    begin
                        cmd.scan_fail = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else if (status.op == bfse_pkg::OP_CLOSE && !status.cell_zero)
                begin
                    if (status.bwd_more)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCANB;
                    end
                    else if (status.out_free)
                    begin
                        cmd.scan_fail = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else if (status.out_free)
                begin
                    cmd.exec_plain = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SCANF, ST_SCANB:
            begin
                cmd.fwd = (state_reg == ST_SCANF);
                if (status.hit)
                begin
                    if (status.out_free)
                    begin
                        cmd.scan_found = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (cmd.fwd ? status.fwd_more : status.bwd_more)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.scan_fail = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* src/bfse_dp.sv */
module bfse_dp #(
    parameter int TAPE_DEPTH = bfse_pkg::TAPE_DEPTH_DEF,
    parameter int PROG_DEPTH = bfse_pkg::PROG_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        program_char,
    input  logic [7:0]        input_byte,
    input  bfse_pkg::cmd_t    cmd,
    output bfse_pkg::status_t status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata
);

    localparam int TW = $clog2(TAPE_DEPTH);
    localparam int PA = $clog2(PROG_DEPTH);
    localparam int PW = $clog2(PROG_DEPTH + 1);

    logic [7:0] prog_mem [PROG_DEPTH];
    logic [7:0] tape_mem [TAPE_DEPTH];

    logic [PW-1:0]              pc_reg, pc_next;
    logic [PW-1:0]              len_reg;
    logic [TW-1:0]              dp_reg, dp_next;
    logic [bfse_pkg::ERR_W-1:0] err_reg, err_next;
    logic [PW-1:0]              pos_reg;
    logic [PW-1:0]              depth_reg, depth_next;
    logic [TW-1:0]              clr_reg;
    logic [7:0]                 ibyte_reg;
    logic [7:0]                 prog_rd_reg;
    logic [7:0]                 cell_reg;
    logic                       m_tvalid_reg;
    logic [31:0]                m_tdata_reg;

    logic [PW-1:0]  pos_inc, pos_dec, pos_move;
    logic           prog_re;
    logic [PA-1:0]  prog_raddr;
    logic           tape_we;
    logic [TW-1:0]  tape_waddr;
    logic [7:0]     tape_wdata;
    logic           push;
    logic           res_ov, res_tk, res_halted;
    logic [7:0]     res_ob;
    bfse_pkg::op_t  op;

    assign op       = bfse_pkg::decode_op(prog_rd_reg);
    assign pos_inc  = pos_reg + PW'(1);
    assign pos_dec  = pos_reg - PW'(1);
    assign pos_move = cmd.fwd ? pos_inc : pos_dec;

    always_comb
    begin
        depth_next = depth_reg;
        if (prog_rd_reg == bfse_pkg::CH_OPEN)
        begin
            depth_next = cmd.fwd ? depth_reg + PW'(1) : depth_reg - PW'(1);
        end
        else if (prog_rd_reg == bfse_pkg::CH_CLOSE)
        begin
            depth_next = cmd.fwd ? depth_reg - PW'(1) : depth_reg + PW'(1);
        end
    end

    assign status.clear_last = (clr_reg == TW'(TAPE_DEPTH - 1));
    assign status.halted     = (err_reg != bfse_pkg::ERR_NONE) || (pc_reg >= len_reg);
    assign status.out_free   = !m_tvalid_reg || m_tready;
    assign status.op         = op;
    assign status.cell_zero  = (cell_reg == 8'd0);
    assign status.fwd_more   = (pos_inc < len_reg);
    assign status.bwd_more   = (pos_reg != '0);
    assign status.hit        = (depth_next == '0);

    assign prog_re    = cmd.step_start || cmd.scan_start || cmd.scan_step;
    assign prog_raddr = cmd.step_start ? pc_reg[PA-1:0] : pos_move[PA-1:0];

    always_comb
    begin
        pc_next    = pc_reg;
        dp_next    = dp_reg;
        err_next   = err_reg;
        res_ov     = 1'b0;
        res_ob     = 8'd0;
        res_tk     = 1'b0;
        push       = 1'b0;
        tape_we    = 1'b0;
        tape_waddr = dp_reg;
        tape_wdata = 8'd0;
        if (cmd.clear_wr)
        begin
            tape_we    = 1'b1;
            tape_waddr = clr_reg;
        end
        if (cmd.exec_halted)
        begin
            push = 1'b1;
        end
        if (cmd.exec_plain)
        begin
            push    = 1'b1;
            pc_next = pc_reg + PW'(1);
            case (op)
                bfse_pkg::OP_RIGHT:
                begin
                    if (dp_reg == TW'(TAPE_DEPTH - 1))
                    begin
                        err_next = bfse_pkg::ERR_OVF;
                        pc_next  = pc_reg;
                    end
                    else
                    begin
                        dp_next = dp_reg + TW'(1);
                    end
                end
                bfse_pkg::OP_LEFT:
                begin
                    if (dp_reg == '0)
                    begin
                        err_next = bfse_pkg::ERR_UNF;
                        pc_next  = pc_reg;
                    end
                    else
                    begin
                        dp_next = dp_reg - TW'(1);
                    end
                end
                bfse_pkg::OP_INC:
                begin
                    tape_we    = 1'b1;
                    tape_wdata = cell_reg + 8'd1;
                end
                bfse_pkg::OP_DEC:
                begin
                    tape_we    = 1'b1;
                    tape_wdata = cell_reg - 8'd1;
                end
                bfse_pkg::OP_OUT:
                begin
                    res_ov = 1'b1;
                    res_ob = cell_reg;
                end
                bfse_pkg::OP_IN:
                begin
                    tape_we    = 1'b1;
                    tape_wdata = ibyte_reg;
                    res_tk     = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.scan_found)
        begin
            push    = 1'b1;
            pc_next = pos_inc;
        end
        if (cmd.scan_fail)
        begin
            push     = 1'b1;
            err_next = cmd.fwd ? bfse_pkg::ERR_OPEN : bfse_pkg::ERR_CLOSE;
        end
    end

    assign res_halted = (err_next != bfse_pkg::ERR_NONE) || (pc_next >= len_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load && len_reg < PW'(PROG_DEPTH))
        begin
            prog_mem[len_reg[PA-1:0]] <= program_char;
        end
        if (prog_re)
        begin
            prog_rd_reg <= prog_mem[prog_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        if (cmd.step_start)
        begin
            cell_reg <= tape_mem[dp_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= '0;
            len_reg      <= '0;
            dp_reg       <= '0;
            err_reg      <= bfse_pkg::ERR_NONE;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            pc_reg  <= pc_next;
            dp_reg  <= dp_next;
            err_reg <= err_next;
            if (cmd.clear_wr && !status.clear_last)
            begin
                clr_reg <= clr_reg + TW'(1);
            end
            if (cmd.load && len_reg < PW'(PROG_DEPTH))
            begin
                len_reg <= len_reg + PW'(1);
            end
            if (push)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step_start)
        begin
            ibyte_reg <= input_byte;
            pos_reg   <= pc_reg;
        end
        if (cmd.scan_start)
        begin
            pos_reg   <= pos_move;
            depth_reg <= PW'(1);
        end
        if (cmd.scan_step)
        begin
            pos_reg   <= pos_move;
            depth_reg <= depth_next;
        end
        if (push)
        begin
            m_tdata_reg <= {5'd0, bfse_pkg::NPC_W'(pc_next), err_next, res_halted,
                            res_tk, res_ob, res_ov};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* src/brainfuck_step_engine_core.sv */
// Channel | Dir | Signals                      | Item
// s       | in  | s_tvalid s_tready s_tdata/user | load byte or step request
// m       | out | m_tvalid m_tready m_tdata      | one result per step item
//
// Load item: appends one program byte if the store has room. Plain step: program/tape read, then execute.
// Bracket jump: program/tape read, then a scan for the match, one program store read per cycle.
// After reset the tape is zeroed one cell a cycle; no items are taken meanwhile.
// A step that finishes while a result is still unread waits for the output register.
module brainfuck_step_engine_core #(
    parameter int TAPE_DEPTH = bfse_pkg::TAPE_DEPTH_DEF,
    parameter int PROG_DEPTH = bfse_pkg::PROG_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // program_char[7:0], input_byte[15:8]
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // out_valid[0], out_byte[8:1], input_taken[9],
                                   // halted[10], error[13:11], next_pc[26:14], zero pad
);

    bfse_pkg::cmd_t    cmd;
    bfse_pkg::status_t status;

    bfse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bfse_dp #(
        .TAPE_DEPTH (TAPE_DEPTH),
        .PROG_DEPTH (PROG_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .program_char (s_tdata[7:0]),
        .input_byte   (s_tdata[15:8]),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule
